// ===== hw/rtl/mtg_pkg.sv =====
// Package for the MT19937 generator: constants, command codes, channel payloads
// and controller types. No dependencies.
`timescale 1ns / 1ps
package mtg_pkg;
  localparam int unsigned StateDepth = 624;
  localparam int unsigned AddrW = 10;
  localparam logic [AddrW-1:0] LastAddr = 10'd623;
  localparam logic [AddrW-1:0] TapOffset = 10'd397;
  localparam logic [31:0] TwistMatrix = 32'h9908b0df;
  localparam logic [31:0] SeedMult = 32'd1812433253;
  localparam logic [31:0] ArrayMultA = 32'd1664525;
  localparam logic [31:0] ArrayMultB = 32'd1566083941;
  localparam logic [31:0] ArrayBaseSeed = 32'd19650218;
  localparam logic [31:0] DefaultSeed = 32'd5489;
  localparam logic [31:0] HighBit = 32'h80000000;
  localparam logic [31:0] TemperB = 32'h9d2c5680;
  localparam logic [31:0] TemperC = 32'hefc60000;

  typedef enum logic [1:0] {
    CMD_SEED = 2'd0,
    CMD_KEY  = 2'd1,
    CMD_INIT = 2'd2,
    CMD_DRAW = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] data_word;
  } req_t;

  typedef struct packed {
    logic [31:0] random_word;
  } rsp_t;

  // Datapath operation selected by the controller.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_SEED  = 3'd1,
    OP_PASSA = 3'd2,
    OP_PASSB = 3'd3,
    OP_TWIST = 3'd4
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             start;
    logic [31:0]      seed;
    logic             fin_word0;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_stat_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction
endpackage

// ===== hw/rtl/mtg_stream_if.sv =====
// Valid/ready channel carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface mtg_stream_if #(parameter type payload_t = logic [31:0]);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mtg_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module mtg_ram #(
  parameter int Width = 32,
  parameter int Depth = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/mtg_datapath.sv =====
// State-word datapath: seeding, array passes and twist sweeps over the state
// words kept in three RAM copies. Depends on mtg_pkg, mtg_ram.
`timescale 1ns / 1ps
module mtg_datapath #(
  parameter int KeyDepth = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mtg_pkg::dp_cmd_t              cmd,
  output mtg_pkg::dp_stat_t             stat,
  input  logic                          key_we,
  input  logic [$clog2(KeyDepth+1)-1:0] key_count,
  input  logic [31:0]                   key_wdata,
  input  logic [mtg_pkg::AddrW-1:0]     out_addr,
  output logic [31:0]                   out_word
);
  localparam int KW = $clog2(KeyDepth+1);
  localparam int KA = (KeyDepth > 1) ? $clog2(KeyDepth) : 1;
  localparam logic [KW-1:0] KOne = KW'(1);

  // Every write goes to three copies so the sweeps can read cur, next and tap.
  // Ops run word by word through phases: phase 0 issue reads, 1 wait,
  // 2 multiply, 3 combine and write.
  logic [mtg_pkg::AddrW-1:0] pos, ra0, ra1, ra2, wa;
  logic [31:0] rd0, rd1, rd2, wd, prev, prod, kword;
  logic [31:0] mul_a, mul_b;
  logic we;
  logic [1:0] phase;
  logic [10:0] left;
  logic [KA-1:0] kix;
  logic [KA-1:0] key_raddr;
  logic [KA-1:0] key_waddr;
  logic [KW-1:0] kix_w;
  logic running, word0_pend, wrap;
  mtg_pkg::op_t op;
  logic [mtg_pkg::AddrW-1:0] nx_addr, tp_addr, tp_sum;
  logic [10:0] tp_wide;

  mtg_ram #(.Width(32), .Depth(mtg_pkg::StateDepth)) u_cur (
    .clk, .we, .waddr(wa), .wdata(wd), .raddr(ra0), .rdata(rd0));
  mtg_ram #(.Width(32), .Depth(mtg_pkg::StateDepth)) u_nxt (
    .clk, .we, .waddr(wa), .wdata(wd), .raddr(ra1), .rdata(rd1));
  mtg_ram #(.Width(32), .Depth(mtg_pkg::StateDepth)) u_tap (
    .clk, .we, .waddr(wa), .wdata(wd), .raddr(ra2), .rdata(rd2));
  assign key_waddr = KA'(key_count);
  mtg_ram #(.Width(32), .Depth(KeyDepth)) u_key (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(kword));

  assign out_word = rd0;
  assign key_raddr = kix;
  assign kix_w = KW'(kix);
  assign nx_addr = (pos == mtg_pkg::LastAddr) ? '0 : pos + 1'b1;
  assign tp_wide = {1'b0, pos} + {1'b0, mtg_pkg::TapOffset};
  assign tp_sum = (tp_wide >= 11'd624) ? 10'(tp_wide - 11'd624) : tp_wide[9:0];
  assign tp_addr = tp_sum;
  assign stat.busy = running;
  assign wrap = (op == mtg_pkg::OP_PASSA || op == mtg_pkg::OP_PASSB) &&
                pos == mtg_pkg::LastAddr;

  always_comb begin
    ra0 = out_addr;
    ra1 = nx_addr;
    ra2 = tp_addr;
    if (running) begin
      case (op)
        mtg_pkg::OP_PASSA, mtg_pkg::OP_PASSB: begin
          ra0 = pos;
          ra1 = pos - 1'b1;
        end
        mtg_pkg::OP_TWIST: ra0 = pos;
        default: ra0 = pos - 1'b1;
      endcase
    end
  end

  always_comb begin
    mul_a = prev ^ (prev >> 30);
    case (op)
      mtg_pkg::OP_PASSA: mul_b = mtg_pkg::ArrayMultA;
      mtg_pkg::OP_PASSB: mul_b = mtg_pkg::ArrayMultB;
      default: mul_b = mtg_pkg::SeedMult;
    endcase
  end

  always_comb begin
    logic [31:0] y;
    y = '0;
    we = 1'b0;
    wa = pos;
    wd = '0;
    if (running && word0_pend) begin
      we = 1'b1;
      wa = '0;
      wd = cmd.fin_word0 && left == '0 ? mtg_pkg::HighBit : prev;
    end else if (running && phase == 2'd3) begin
      we = 1'b1;
      case (op)
        mtg_pkg::OP_SEED: wd = prod + 32'(pos);
        mtg_pkg::OP_PASSA: wd = (rd0 ^ prod) + kword + 32'(kix);
        mtg_pkg::OP_PASSB: wd = (rd0 ^ prod) - 32'(pos);
        mtg_pkg::OP_TWIST: begin
          y = (rd0 & mtg_pkg::HighBit) | (rd1 & ~mtg_pkg::HighBit);
          wd = rd2 ^ (y >> 1) ^ (y[0] ? mtg_pkg::TwistMatrix : '0);
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      word0_pend <= 1'b0;
      phase <= '0;
    end else if (cmd.start) begin
      running <= 1'b1;
      word0_pend <= cmd.op == mtg_pkg::OP_SEED;
      op <= cmd.op;
      phase <= '0;
      kix <= '0;
      case (cmd.op)
        mtg_pkg::OP_SEED: begin
          pos <= 10'd1;
          prev <= cmd.seed;
          left <= 11'd623;
        end
        mtg_pkg::OP_PASSA: begin
          pos <= 10'd1;
          left <= (KW > 10 && key_count > KW'(624)) ? 11'(key_count) : 11'd624;
        end
        mtg_pkg::OP_PASSB: left <= 11'd623;
        default: begin
          pos <= '0;
          left <= 11'd624;
        end
      endcase
    end else if (running) begin
      if (word0_pend) begin
        word0_pend <= 1'b0;
        pos <= 10'd1;
        if (left == '0) running <= 1'b0;
      end else begin
        phase <= phase + 1'b1;
        if (phase == 2'd1 && op != mtg_pkg::OP_SEED && op != mtg_pkg::OP_TWIST)
          prev <= rd1;
        if (phase == 2'd2) prod <= mul_a * mul_b;
        if (phase == 2'd3) begin
          prev <= wd;
          left <= left - 1'b1;
          if (op == mtg_pkg::OP_PASSA)
            kix <= (kix_w + KOne >= key_count) ? '0 : kix + 1'b1;
          if (!wrap) pos <= nx_addr;
          if (wrap || (left == 11'd1 && cmd.fin_word0)) word0_pend <= 1'b1;
          if (left == 11'd1 && !wrap) running <= cmd.fin_word0;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/mtg_controller.sv =====
// Command sequencer for the MT19937 generator: decodes requests and steps the
// datapath through seed, array passes and twist. Depends on mtg_pkg.
`timescale 1ns / 1ps
module mtg_controller #(
  parameter int KeyDepth = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_cmd,
  input  logic [31:0]                   in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_word,
  output mtg_pkg::dp_cmd_t              cmd,
  input  mtg_pkg::dp_stat_t             stat,
  output logic                          key_we,
  output logic [$clog2(KeyDepth+1)-1:0] key_count,
  output logic [mtg_pkg::AddrW-1:0]     out_addr,
  input  logic [31:0]                   ram_word
);
  localparam int KW = $clog2(KeyDepth+1);
  localparam logic [KW-1:0] KFull = KW'(KeyDepth);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SEED  = 8'b0000_0010,
    S_PASSA = 8'b0000_0100,
    S_PASSB = 8'b0000_1000,
    S_TWIST = 8'b0001_0000,
    S_READ  = 8'b0010_0000,
    S_TEMP  = 8'b0100_0000,
    S_WAIT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic [10:0] read_index;
  logic draw_pend, init_pend, started;

  assign in_ready = state == S_IDLE && !out_valid;
  assign key_we = in_valid && in_ready && in_cmd == mtg_pkg::CMD_KEY && key_count != KFull;
  assign out_addr = read_index[mtg_pkg::AddrW-1:0];

  always_comb begin
    cmd = '0;
    cmd.seed = mtg_pkg::DefaultSeed;
    cmd.fin_word0 = state == S_PASSB;
    if (state == S_IDLE && in_valid && in_ready) begin
      case (in_cmd)
        mtg_pkg::CMD_SEED: begin
          cmd.start = 1'b1; cmd.op = mtg_pkg::OP_SEED; cmd.seed = in_data;
        end
        mtg_pkg::CMD_INIT: if (key_count != '0) begin
          cmd.start = 1'b1; cmd.op = mtg_pkg::OP_SEED; cmd.seed = mtg_pkg::ArrayBaseSeed;
        end
        mtg_pkg::CMD_DRAW: if (read_index >= 11'd624) begin
          cmd.start = 1'b1;
          cmd.op = read_index == 11'd624 ? mtg_pkg::OP_TWIST : mtg_pkg::OP_SEED;
        end
        default: ;
      endcase
    end else if (!started && !stat.busy) begin
      case (state)
        S_SEED: if (init_pend) begin cmd.start = 1'b1; cmd.op = mtg_pkg::OP_PASSA; end
          else if (draw_pend) begin cmd.start = 1'b1; cmd.op = mtg_pkg::OP_TWIST; end
        S_PASSA: begin cmd.start = 1'b1; cmd.op = mtg_pkg::OP_PASSB; end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        case (in_cmd)
          mtg_pkg::CMD_SEED: state_next = S_SEED;
          mtg_pkg::CMD_INIT: if (key_count != '0) state_next = S_SEED;
          mtg_pkg::CMD_DRAW: state_next = read_index == 11'd624 ? S_TWIST
            : read_index > 11'd624 ? S_SEED : S_READ;
          default: ;
        endcase
      end
      S_SEED: if (!started && !stat.busy)
        state_next = init_pend ? S_PASSA : draw_pend ? S_TWIST : S_IDLE;
      S_PASSA: if (!started && !stat.busy) state_next = S_PASSB;
      S_PASSB: if (!started && !stat.busy) state_next = S_IDLE;
      S_TWIST: if (!started && !stat.busy) state_next = S_READ;
      S_READ: state_next = S_TEMP;
      S_TEMP: state_next = S_IDLE;
      S_WAIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      read_index <= 11'd625;
      key_count <= '0;
      draw_pend <= 1'b0;
      init_pend <= 1'b0;
      out_valid <= 1'b0;
      started <= 1'b0;
    end else begin
      state <= state_next;
      started <= cmd.start;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (key_we) key_count <= key_count + 1'b1;
      if (state == S_PASSA && state_next == S_PASSB) key_count <= '0;
      if (state == S_IDLE && in_valid && in_ready) begin
        draw_pend <= in_cmd == mtg_pkg::CMD_DRAW;
        init_pend <= in_cmd == mtg_pkg::CMD_INIT;
        if (in_cmd == mtg_pkg::CMD_SEED) read_index <= 11'd624;
        if (in_cmd == mtg_pkg::CMD_INIT && key_count != '0) read_index <= 11'd624;
      end
      if (state == S_TWIST && state_next == S_READ) read_index <= '0;
      if (state == S_SEED && state_next == S_TWIST) read_index <= 11'd624;
      if (state == S_TEMP) begin
        out_word <= mtg_pkg::temper(ram_word);
        out_valid <= 1'b1;
        read_index <= read_index + 1'b1;
      end
    end
  end
endmodule

// ===== hw/rtl/mersenne_twister_generator.sv =====
// Top level of the MT19937 generator: request and result channels, controller
// and datapath. Depends on mtg_pkg, mtg_stream_if, mtg_controller, mtg_datapath.
`timescale 1ns / 1ps
// One request is handled at a time; the next is taken only after the previous
// result has been accepted. A draw that finds unused state words reads and
// tempers the next word before offering it. The 624 state words sit in RAM
// and are rebuilt word by word through one shared 32x32 multiplier and the
// RAM ports. A draw that needs a twist first runs a twist sweep; a first draw
// before any seeding first seeds with the default seed. An array
// initialization runs a seed and two array passes, the first pass longer for
// a key beyond 624 words. No clearing pass runs after reset.
module mersenne_twister_generator #(
  parameter int KeyDepth = 16
) (
  input logic clk,
  input logic rst,
  mtg_stream_if.sink   req,
  mtg_stream_if.source rsp
);
  localparam int KW = $clog2(KeyDepth+1);
  mtg_pkg::dp_cmd_t  cmd;
  mtg_pkg::dp_stat_t stat;
  logic key_we;
  logic [KW-1:0] key_count;
  logic [mtg_pkg::AddrW-1:0] out_addr;
  logic [31:0] ram_word;

  mtg_controller #(.KeyDepth(KeyDepth)) u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .in_cmd(req.payload.command), .in_data(req.payload.data_word),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .out_word(rsp.payload.random_word),
    .cmd, .stat, .key_we, .key_count, .out_addr, .ram_word);

  mtg_datapath #(.KeyDepth(KeyDepth)) u_dp (
    .clk, .rst, .cmd, .stat, .key_we, .key_count,
    .key_wdata(req.payload.data_word), .out_addr, .out_word(ram_word));
endmodule

// ===== hw/rtl/mtg_checker.sv =====
// Port-level checks for the MT19937 generator, bound to the top level.
// Depends on mersenne_twister_generator.
`timescale 1ns / 1ps
module mtg_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [31:0] rsp_word
);
  a_no_ready_while_out: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken while result pending");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
    else $error("result dropped");
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result after reset");
endmodule

bind mersenne_twister_generator mtg_checker u_chk (
  .clk, .rst, .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_word(rsp.payload.random_word));
